// ===== rtl/core/brf_pkg.sv =====
// Shared types and operation codes for the byte ring FIFO with search.
`default_nettype none

package brf_pkg;

   // Operation codes carried on req_func
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_SEARCH = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN
   } state_type;

   // Commands from the sequencer to the ring storage
   typedef struct packed {
      logic push;        // write byte at write index, advance it
      logic pop;         // advance read index
      logic clear;       // both indices to zero
      logic scan_load;   // scan pointer takes the read index
      logic scan_step;   // scan pointer advances, read its next slot
   } ring_ctl_type;

   // Status from the ring storage
   typedef struct packed {
      logic empty;
      logic full;
      logic scan_last;   // slot after the scan pointer is the write index
   } ring_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/brf_ring.sv =====
// Ring storage: byte memory, write/read indices and scan pointer.
`default_nettype none

module brf_ring #(
   parameter int DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire brf_pkg::ring_ctl_type ctl,
   input  wire logic [7:0]            wr_byte,
   output      logic [7:0]            rd_byte,
   output      brf_pkg::ring_sts_type sts
);
   import brf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]    store_ff [DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [AW-1:0] raddr;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   // read port: head slot by default, next scan slot while scanning
   assign raddr = ctl.scan_step ? nxt(scan_ff) : rd_idx_ff;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         store_ff[wr_idx_ff] <= wr_byte;
      end
      rdata_ff <= store_ff[raddr];
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      scan_in   = scan_ff;
      if (ctl.clear) begin
         wr_idx_in = '0;
         rd_idx_in = '0;
      end else begin
         if (ctl.push) wr_idx_in = nxt(wr_idx_ff);
         if (ctl.pop)  rd_idx_in = nxt(rd_idx_ff);
      end
      if (ctl.scan_load) begin
         scan_in = rd_idx_ff;
      end else if (ctl.scan_step) begin
         scan_in = nxt(scan_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         scan_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         scan_ff   <= scan_in;
      end
   end

   assign rd_byte       = rdata_ff;
   assign sts.empty     = (wr_idx_ff == rd_idx_ff);
   assign sts.full      = (nxt(wr_idx_ff) == rd_idx_ff);
   assign sts.scan_last = (nxt(scan_ff) == wr_idx_ff);

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_search_unit.sv =====
// Top level: byte ring FIFO with push, pop, clear and search operations.
// Usage:
//  - req channel (req_valid/req_stall) carries one operation per transfer:
//    push a byte, pop the oldest byte, clear, or search for a byte value.
//  - rsp channel (rsp_valid/rsp_stall) returns exactly one result per
//    operation, in order: accepted, popped byte, found flag and offset,
//    plus empty/full status after the operation.
//  - The ring holds at most DEPTH-1 bytes; push when full and pop when
//    empty are refused with rsp_accepted low.
// Operation flow:
//  - push, clear, and pop/search on an empty ring: the output register
//    takes the result at the end of the transfer cycle; pushes stream at
//    one per cycle while rsp_stall is low.
//  - pop: head byte from the synchronous memory read, then the output register.
//  - search: bytes are compared from the oldest until a match or the newest;
//    the single memory read port visits one stored byte per cycle.
// One operation is in flight at a time. A result waiting in the output
// register does not block the next transfer once rsp_stall drops: the new
// item is taken in the same cycle as the old result leaves.
// Reset (synchronous) empties the ring and drops any pending result; memory is kept.
`default_nettype none

module byte_ring_fifo_with_search_unit #(
   parameter int DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_push_byte,
   input  wire logic [7:0] req_search_byte,
   // result channel
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_accepted,
   output      logic [7:0] rsp_pop_byte,
   output      logic       rsp_found,
   output      logic [7:0] rsp_found_offset,
   output      logic       rsp_is_empty,
   output      logic       rsp_is_full
);
   import brf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = (AW > 8) ? AW : 8;

   state_type     state_ff, state_in;
   ring_ctl_type  ctl;
   ring_sts_type  sts;
   logic [7:0]    rd_byte;

   logic          accept;
   logic          rsp_free;
   logic          load;

   logic [7:0]    key_ff, key_in;
   logic [AW-1:0] cnt_ff, cnt_in;     // offset of the byte now being compared
   logic [OW-1:0] cnt_ext;
   logic          hit;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          accepted_ff, accepted_in;
   logic [7:0]    pop_byte_ff, pop_byte_in;
   logic          found_ff, found_in;
   logic [7:0]    offset_ff, offset_in;

   brf_ring #(.DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_byte (req_push_byte),
      .rd_byte (rd_byte),
      .sts     (sts)
   );

   // output register is free now or frees up at this edge
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;

   assign hit     = (rd_byte == key_ff);
   assign cnt_ext = OW'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_POP && !sts.empty) begin
                  state_in = ST_POP;
               end else if (req_func == FUNC_SEARCH && !sts.empty) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit || sts.scan_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ring commands and result load
   always_comb begin
      ctl         = '0;
      load        = 1'b0;
      accepted_in = 1'b0;
      pop_byte_in = '0;
      found_in    = 1'b0;
      offset_in   = '0;
      key_in      = key_ff;
      cnt_in      = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PUSH: begin
                     ctl.push    = !sts.full;
                     accepted_in = !sts.full;
                     load        = 1'b1;
                  end
                  FUNC_POP: begin
                     // head slot is read this cycle; refused pop answers now
                     load = sts.empty;
                  end
                  FUNC_CLEAR: begin
                     ctl.clear = 1'b1;
                     load      = 1'b1;
                  end
                  FUNC_SEARCH: begin
                     key_in        = req_search_byte;
                     cnt_in        = '0;
                     ctl.scan_load = !sts.empty;
                     load          = sts.empty;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            ctl.pop     = 1'b1;
            load        = 1'b1;
            accepted_in = 1'b1;
            pop_byte_in = rd_byte;
         end
         ST_SCAN: begin
            if (hit) begin
               load      = 1'b1;
               found_in  = 1'b1;
               offset_in = cnt_ext[7:0];
            end else if (sts.scan_last) begin
               load = 1'b1;
            end else begin
               ctl.scan_step = 1'b1;
               cnt_in        = cnt_ff + AW'(1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      if (load) begin
         accepted_ff <= accepted_in;
         pop_byte_ff <= pop_byte_in;
         found_ff    <= found_in;
         offset_ff   <= offset_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_pop_byte     = pop_byte_ff;
   assign rsp_found        = found_ff;
   assign rsp_found_offset = offset_ff;
   // indices only move at the edge a result loads, so live status is the
   // status after the operation shown
   assign rsp_is_empty     = sts.empty;
   assign rsp_is_full      = sts.full;

   a_not_empty_and_full: assert property (@(posedge clock) disable iff (reset)
      !(sts.empty && sts.full))
      else $error("ring reports empty and full at once");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !sts.empty)
      else $error("pop read issued on empty ring");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while an operation is in flight");

   a_found_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (!sts.empty && !accepted_ff))
      else $error("search hit reported with empty ring or accepted flag");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> !sts.empty)
      else $error("ring empty after a stored push");

endmodule

`default_nettype wire
